@@ rtl/array_list_engine_macros.svh @@
// assertion helpers for the checker file
`ifndef ARRAY_LIST_ENGINE_MACROS_SVH
`define ARRAY_LIST_ENGINE_MACROS_SVH

// clocked property, masked while reset is asserted
`define ALC_ASSERT(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error(msg);

// same, on the default clock and reset names
`define ALC_CHECK(label, prop, msg) `ALC_ASSERT(label, clk, rst_n, prop, msg)

`endif

@@ rtl/alc_pkg.sv @@
`default_nettype none

package alc_pkg;

    typedef enum logic [3:0] {
        CMD_PUSH_BACK  = 4'd0,
        CMD_PUSH_FRONT = 4'd1,
        CMD_POP_BACK   = 4'd2,
        CMD_POP_FRONT  = 4'd3,
        CMD_INSERT     = 4'd4,
        CMD_ERASE      = 4'd5,
        CMD_FIND       = 4'd6,
        CMD_MODIFY     = 4'd7,
        CMD_READ       = 4'd8
    } cmd_e_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_e_t;

    typedef enum logic [1:0] {
        CM_HOLD       = 2'd0,
        CM_LOAD       = 2'd1,
        CM_SHIFT_UP   = 2'd2,
        CM_SHIFT_DOWN = 2'd3
    } cell_mode_t;

    typedef struct packed {
        logic [3:0]          command;
        logic [7:0]          position;
        logic signed [31:0]  value;
    } cmd_word_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [7:0]          found_index;
        logic signed [31:0]  read_value;
        logic [8:0]          entry_count;
    } rsp_word_t;

    typedef struct packed {
        cell_mode_t   mode;
        logic [31:0]  value;
    } cell_wr_t;

    typedef struct packed {
        logic         find;
        logic [31:0]  value;
    } scan_query_t;

    typedef struct packed {
        logic         hit;
        logic [31:0]  data;
    } scan_carry_t;

endpackage

`default_nettype wire

@@ rtl/alc_cell.sv @@
`default_nettype none

module alc_cell #(
    parameter int IDX = 0,
    parameter int IW  = 8,
    parameter int CW  = 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  alc_pkg::cell_wr_t     wr,
    input  logic [IW-1:0]         wr_pos,
    input  alc_pkg::scan_query_t  query,
    input  logic [IW-1:0]         query_pos,
    input  logic [CW-1:0]         count,
    input  logic [31:0]           left_data,
    input  logic [31:0]           right_data,
    input  alc_pkg::scan_carry_t  carry_in,
    output logic [31:0]           data,
    output alc_pkg::scan_carry_t  carry_out
);

    localparam logic [IW-1:0] MY_POS = IW'(IDX);
    localparam logic [CW-1:0] MY_CNT = CW'(IDX);

    logic [31:0]           entry_reg;
    logic [31:0]           entry_next;
    alc_pkg::scan_carry_t  carry_reg;
    alc_pkg::scan_carry_t  carry_next;
    logic                  at_wr;
    logic                  above_wr;
    logic                  hit_here;

    assign at_wr    = (MY_POS == wr_pos);
    assign above_wr = (MY_POS > wr_pos);

    always_comb
    begin
        entry_next = entry_reg;
        case (wr.mode)
            alc_pkg::CM_HOLD:
            begin
                entry_next = entry_reg;
            end
            alc_pkg::CM_LOAD:
            begin
                if (at_wr)
                    entry_next = wr.value;
            end
            alc_pkg::CM_SHIFT_UP:
            begin
                if (at_wr)
                    entry_next = wr.value;
                else if (above_wr)
                    entry_next = left_data;
            end
            alc_pkg::CM_SHIFT_DOWN:
            begin
                if (at_wr || above_wr)
                    entry_next = right_data;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // first match wins, later cells pass it on
    assign hit_here = query.find ? ((query.value == entry_reg) && (MY_CNT < count))
                                 : (MY_POS == query_pos);

    always_comb
    begin
        carry_next = carry_in;
        if (!carry_in.hit && hit_here)
        begin
            carry_next.hit  = 1'b1;
            carry_next.data = query.find ? 32'(IDX) : entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            carry_reg <= '0;
        else
            carry_reg <= carry_next;
    end

    assign data      = entry_reg;
    assign carry_out = carry_reg;

endmodule

`default_nettype wire

@@ rtl/array_list_engine.sv @@
// channel | valid     | ready     | word
// --------+-----------+-----------+---------------------------------------------
// command | cmd_valid | cmd_ready | cmd_data: command, position, value
// result  | rsp_valid | rsp_ready | rsp_data: status, found_index, read_value,
//         |           |           |           entry_count
//
// push, pop, insert, erase, modify, out-of-range read and unused codes: result
// registered on the accept edge, next word accepted in the same cycle the result is taken
// find and in-range read: the carry walks the cell row one cell a cycle, result
// registered once the scan count reaches CAPACITY and the output register is free
// reset clears the count, state and result valid, entries are not cleared
// cmd_ready is low while a scan runs or while an untaken result fills the output register
`default_nettype none

module array_list_engine #(
    parameter int CAPACITY = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  alc_pkg::cmd_word_t  cmd_data,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output alc_pkg::rsp_word_t  rsp_data
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 8) ? CW : 8;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [CW-1:0]       scan_cnt_reg;
    logic [CW-1:0]       scan_cnt_next;
    logic                q_find_reg;
    logic [IW-1:0]       q_pos_reg;
    logic [31:0]         q_val_reg;
    logic                rsp_valid_reg;
    alc_pkg::rsp_word_t  rsp_reg;

    logic                accept;
    logic                out_free;
    logic                full;
    logic                empty;
    logic                inrange;
    logic [IW-1:0]       pos_i;
    logic                start_scan;
    logic                scan_done;
    alc_pkg::status_e_t  imm_status;
    alc_pkg::cell_mode_t dec_mode;
    logic [IW-1:0]       dec_pos;
    logic [CW-1:0]       dec_count;
    alc_pkg::cell_wr_t   wr;
    alc_pkg::scan_query_t query;
    alc_pkg::rsp_word_t  scan_rsp;

    logic [31:0]          entry_w [CAPACITY];
    logic [31:0]          left_w  [CAPACITY];
    logic [31:0]          right_w [CAPACITY];
    alc_pkg::scan_carry_t carry_w [CAPACITY+1];

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign cmd_ready = (state_reg == S_IDLE) && out_free;
    assign accept    = cmd_valid && cmd_ready;
    assign full      = (count_reg == CAP_CNT);
    assign empty     = (count_reg == '0);
    assign inrange   = (PW'(cmd_data.position) < PW'(count_reg));
    assign pos_i     = IW'(cmd_data.position);
    assign scan_done = (state_reg == S_SCAN) && (scan_cnt_reg == CAP_CNT);

    always_comb
    begin
        imm_status = alc_pkg::ST_OK;
        dec_mode   = alc_pkg::CM_HOLD;
        dec_pos    = pos_i;
        dec_count  = count_reg;
        start_scan = 1'b0;
        case (cmd_data.command)
            alc_pkg::CMD_PUSH_BACK:
            begin
                if (full)
                    imm_status = alc_pkg::ST_FULL;
                else
                begin
                    dec_mode  = alc_pkg::CM_LOAD;
                    dec_pos   = IW'(count_reg);
                    dec_count = count_reg + CW'(1);
                end
            end
            alc_pkg::CMD_PUSH_FRONT:
            begin
                if (full)
                    imm_status = alc_pkg::ST_FULL;
                else
                begin
                    dec_mode  = alc_pkg::CM_SHIFT_UP;
                    dec_pos   = '0;
                    dec_count = count_reg + CW'(1);
                end
            end
            alc_pkg::CMD_POP_BACK:
            begin
                if (empty)
                    imm_status = alc_pkg::ST_EMPTY;
                else
                    dec_count = count_reg - CW'(1);
            end
            alc_pkg::CMD_POP_FRONT:
            begin
                if (empty)
                    imm_status = alc_pkg::ST_EMPTY;
                else
                begin
                    dec_mode  = alc_pkg::CM_SHIFT_DOWN;
                    dec_pos   = '0;
                    dec_count = count_reg - CW'(1);
                end
            end
            alc_pkg::CMD_INSERT:
            begin
                if (!inrange)
                    imm_status = alc_pkg::ST_RANGE;
                else if (full)
                    imm_status = alc_pkg::ST_FULL;
                else
                begin
                    dec_mode  = alc_pkg::CM_SHIFT_UP;
                    dec_count = count_reg + CW'(1);
                end
            end
            alc_pkg::CMD_ERASE:
            begin
                if (!inrange)
                    imm_status = alc_pkg::ST_RANGE;
                else
                begin
                    dec_mode  = alc_pkg::CM_SHIFT_DOWN;
                    dec_count = count_reg - CW'(1);
                end
            end
            alc_pkg::CMD_FIND:
            begin
                start_scan = 1'b1;
            end
            alc_pkg::CMD_MODIFY:
            begin
                if (!inrange)
                    imm_status = alc_pkg::ST_RANGE;
                else
                    dec_mode = alc_pkg::CM_LOAD;
            end
            alc_pkg::CMD_READ:
            begin
                if (!inrange)
                    imm_status = alc_pkg::ST_RANGE;
                else
                    start_scan = 1'b1;
            end
            default:
            begin
                imm_status = alc_pkg::ST_OK;
            end
        endcase
    end

    assign wr.mode  = accept ? dec_mode : alc_pkg::CM_HOLD;
    assign wr.value = cmd_data.value;

    assign query.find  = q_find_reg;
    assign query.value = q_val_reg;

    assign carry_w[0] = '0;

    generate
        for (genvar g = 0; g < CAPACITY; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                assign left_w[g] = cmd_data.value;
            end
            else
            begin : g_mid_l
                assign left_w[g] = entry_w[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign right_w[g] = entry_w[g];
            end
            else
            begin : g_mid_r
                assign right_w[g] = entry_w[g+1];
            end

            alc_cell #(
                .IDX (g),
                .IW  (IW),
                .CW  (CW)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .wr         (wr),
                .wr_pos     (dec_pos),
                .query      (query),
                .query_pos  (q_pos_reg),
                .count      (count_reg),
                .left_data  (left_w[g]),
                .right_data (right_w[g]),
                .carry_in   (carry_w[g]),
                .data       (entry_w[g]),
                .carry_out  (carry_w[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        scan_rsp.entry_count = 9'(count_reg);
        if (q_find_reg)
        begin
            scan_rsp.status      = carry_w[CAPACITY].hit ? alc_pkg::ST_OK
                                                         : alc_pkg::ST_NOTFOUND;
            scan_rsp.found_index = carry_w[CAPACITY].hit ? carry_w[CAPACITY].data[7:0]
                                                         : 8'd0;
            scan_rsp.read_value  = '0;
        end
        else
        begin
            scan_rsp.status      = alc_pkg::ST_OK;
            scan_rsp.found_index = 8'd0;
            scan_rsp.read_value  = carry_w[CAPACITY].data;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        count_next    = count_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    count_next = dec_count;
                    if (start_scan)
                    begin
                        state_next    = S_SCAN;
                        scan_cnt_next = '0;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_cnt_reg != CAP_CNT)
                    scan_cnt_next = scan_cnt_reg + CW'(1);
                else if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_cnt_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_cnt_reg <= scan_cnt_next;
            if ((accept && !start_scan) || (scan_done && out_free))
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // query and result words
    always_ff @(posedge clk)
    begin
        if (accept && start_scan)
        begin
            q_find_reg <= (cmd_data.command == alc_pkg::CMD_FIND);
            q_pos_reg  <= pos_i;
            q_val_reg  <= cmd_data.value;
        end
        if (accept && !start_scan)
        begin
            rsp_reg.status      <= imm_status;
            rsp_reg.found_index <= 8'd0;
            rsp_reg.read_value  <= '0;
            rsp_reg.entry_count <= 9'(dec_count);
        end
        else if (scan_done && out_free)
        begin
            rsp_reg <= scan_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

`default_nettype wire

@@ rtl/alc_checker.sv @@
`default_nettype none

`include "array_list_engine_macros.svh"

module alc_checker #(
    parameter int CAPACITY = 256
) (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                cmd_ready,
    input wire logic                rsp_valid,
    input wire logic                rsp_ready,
    input wire alc_pkg::rsp_word_t  rsp_data
);

    localparam logic [8:0] FULL_CNT = 9'(CAPACITY);

    `ALC_CHECK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result word changed while stalled")

    `ALC_CHECK(a_no_accept_blocked, rsp_valid && !rsp_ready |-> !cmd_ready, "command taken while result register blocked")

    `ALC_CHECK(a_full_count, rsp_valid && rsp_data.status == alc_pkg::ST_FULL |-> rsp_data.entry_count == FULL_CNT, "full status with a list that is not full")

    `ALC_CHECK(a_empty_count, rsp_valid && rsp_data.status == alc_pkg::ST_EMPTY |-> rsp_data.entry_count == 9'd0, "empty status with entries held")

    `ALC_CHECK(a_fail_zero, rsp_valid && rsp_data.status != alc_pkg::ST_OK |-> rsp_data.found_index == 8'd0 && rsp_data.read_value == 32'sd0, "failed command returned data")

endmodule

bind array_list_engine alc_checker #(
    .CAPACITY (CAPACITY)
) u_alc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_ready (cmd_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);

`default_nettype wire
